/* sv/dss_pkg.sv */
`default_nettype none

package dss_pkg;

    // element width and default store depth
    localparam int ELEM_W    = 32;
    localparam int DEPTH_DEF = 16;

    // what one cell shows its neighbors
    typedef struct packed {
        logic                     valid;
        logic                     take;
        logic signed [ELEM_W-1:0] data;
    } cell_link_t;

endpackage

`default_nettype wire

/* sv/dss_in_if.sv */
`default_nettype none

interface dss_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [dss_pkg::ELEM_W-1:0] value;
    logic                              last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

`default_nettype wire

/* sv/dss_out_if.sv */
`default_nettype none

interface dss_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [dss_pkg::ELEM_W-1:0] value_res;
    logic                              last_out;
    logic                              overflow;

    modport source (output valid, output value_res, output last_out, output overflow,
                    input ready);
    modport sink   (input valid, input value_res, input last_out, input overflow,
                    output ready);
endinterface

`default_nettype wire

/* sv/dss_cell.sv */
`default_nettype none

module dss_cell (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              insert,
    input  wire logic                              shift,
    input  wire logic signed [dss_pkg::ELEM_W-1:0] x,
    input  wire dss_pkg::cell_link_t               left,
    input  wire dss_pkg::cell_link_t               right,
    output dss_pkg::cell_link_t                    link
);

    logic                              valid_reg;
    logic                              valid_next;
    logic signed [dss_pkg::ELEM_W-1:0] data_reg;
    logic signed [dss_pkg::ELEM_W-1:0] data_next;
    logic                              take;

    // this cell gives way when empty or when the new value is larger
    assign take = !valid_reg || (x > data_reg);

    assign link.valid = valid_reg;
    assign link.take  = take;
    assign link.data  = data_reg;

    // insert moves the tail right, shift pulls the row left toward the head
    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (shift)
        begin
            valid_next = right.valid;
            data_next  = right.data;
        end
        else if (insert && take)
        begin
            valid_next = valid_reg | left.valid;
            data_next  = left.take ? left.data : x;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

`default_nettype wire

/* sv/descending_selection_sorter.sv */
`default_nettype none
// load: one cycle per input item; each item is placed in order by a parallel
//   compare across the cell row as it arrives, or dropped if the row is full
// emit: first result in the cycle after the last item's transfer, then one result
//   per cycle while results.ready is high; n results for n stored elements
// reset clears cell valid bits and control state; no clearing pass is needed

module descending_selection_sorter #(
    parameter int DEPTH = dss_pkg::DEPTH_DEF
) (
    input wire logic  clk,
    input wire logic  rst_n,
    dss_in_if.sink    items,
    dss_out_if.source results
);

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   dropped_reg;
    logic   dropped_next;

    dss_pkg::cell_link_t links [DEPTH];
    dss_pkg::cell_link_t edge_left;
    dss_pkg::cell_link_t edge_right;

    logic in_xfer;
    logic out_xfer;
    logic full;
    logic insert;
    logic shift;

    assign full     = links[DEPTH-1].valid;
    assign in_xfer  = items.valid && items.ready;
    assign out_xfer = results.valid && results.ready;
    assign insert   = in_xfer && !full;
    assign shift    = out_xfer;

    // fixed neighbors at both ends of the row
    assign edge_left  = '{valid: 1'b1, take: 1'b0, data: '0};
    assign edge_right = '{valid: 1'b0, take: 1'b0, data: '0};

    // row of cells, head at index zero holds the largest value
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        dss_pkg::cell_link_t left_l;
        dss_pkg::cell_link_t right_l;

        if (i == 0)
        begin : g_head
            assign left_l = edge_left;
        end
        else
        begin : g_mid_l
            assign left_l = links[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_l = edge_right;
        end
        else
        begin : g_mid_r
            assign right_l = links[i+1];
        end

        dss_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .insert (insert),
            .shift  (shift),
            .x      (items.value),
            .left   (left_l),
            .right  (right_l),
            .link   (links[i])
        );
    end

    // handshake and result fields
    assign items.ready       = (state_reg == ST_LOAD);
    assign results.valid     = (state_reg == ST_EMIT) && links[0].valid;
    assign results.value_res = links[0].data;
    assign results.last_out  = !links[1].valid;
    assign results.overflow  = dropped_reg;

    // run control
    always_comb
    begin
        state_next   = state_reg;
        dropped_next = dropped_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_xfer)
                begin
                    dropped_next = dropped_reg | full;
                    if (items.last)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_xfer && results.last_out)
                begin
                    state_next   = ST_LOAD;
                    dropped_next = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            dropped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            dropped_reg <= dropped_next;
        end
    end

endmodule

`default_nettype wire
